// ===== rtl/core/sorted_histogram_bucket_table_assert.svh =====
// ----------------------------------------------------------------------------
// Bucket table assertion macros
// Shared concurrent check forms for the sorted bucket table RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_HISTOGRAM_BUCKET_TABLE_ASSERT_SVH
`define SORTED_HISTOGRAM_BUCKET_TABLE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define SHBT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bucket table check failed");

// Next-cycle implication, held off during reset.
`define SHBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bucket table check failed");

`endif

// ===== rtl/core/shbt_pkg.sv =====
// ----------------------------------------------------------------------------
// Bucket table package
// Types, codes and key ordering shared by the bucket table cells and top.
// ----------------------------------------------------------------------------
package shbt_pkg;

    localparam int KEY_W    = 16;
    localparam int COUNT_W  = 64;
    localparam int IDX_W    = 16;
    localparam int RANK_W   = 18;
    localparam int OR_FANIN = 16;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_COMMIT
    } t_state;

    // Operation held steady for the whole item.
    typedef struct packed {
        t_func                func;
        logic [KEY_W-1:0]     key;
        logic [COUNT_W-1:0]   amount;
        logic [IDX_W-1:0]     index;
    } t_req;

    // Commit strobes broadcast to every cell.
    typedef struct packed {
        logic upd;
        logic ins;
    } t_cmd;

    // What a cell hands to its right-hand neighbor.
    typedef struct packed {
        logic                 gt;
        logic [KEY_W-1:0]     key;
        logic [COUNT_W-1:0]   count;
    } t_link;

    // A cell's contribution to the OR reduction; zero unless selected.
    typedef struct packed {
        logic                 hit;
        logic [COUNT_W-1:0]   value;
        logic [KEY_W-1:0]     key;
    } t_hit;

    localparam int HIT_W = $bits(t_hit);

    // Sort rank: NaN first, then negative, zero and positive mantissas.
    function automatic logic [RANK_W-1:0] key_rank(input logic [KEY_W-1:0] key);
        logic [7:0] m;
        logic [7:0] eb;
        logic [7:0] mb;
        begin
            m  = key[15:8];
            eb = key[7:0] ^ 8'h80;
            mb = m ^ 8'h80;
            if (m == 8'hFF) begin
                key_rank = {2'd0, eb, 8'd0};
            end else if (m[7]) begin
                key_rank = {2'd1, ~eb, mb};
            end else if (m == 8'd0) begin
                key_rank = {2'd2, eb, 8'd0};
            end else begin
                key_rank = {2'd3, eb, mb};
            end
        end
    endfunction

    // Register levels of the fan-in-16 reduction over n leaves.
    function automatic int reduce_levels(input int n);
        int cnt;
        int rem;
        begin
            cnt = 1;
            rem = (n + OR_FANIN - 1) / OR_FANIN;
            while (rem > 1) begin
                rem = (rem + OR_FANIN - 1) / OR_FANIN;
                cnt = cnt + 1;
            end
            return cnt;
        end
    endfunction

endpackage

// ===== rtl/core/sorted_histogram_bucket_table.sv =====
// ----------------------------------------------------------------------------
// Sorted histogram bucket table
// Sorted log-linear bucket table kept in a row of cells, one per position.
// ----------------------------------------------------------------------------
// Flow: the input beat is registered, the cell results are collected by the
//   registered OR reduction (one level per 16x fan-in), and the result is
//   registered at commit, which waits while an earlier result is unread.
//   A new item is taken only in idle, after the last one has committed.
// Reset: synchronous, active low; clears the entry count and handshake state,
//   cell contents are left as they are and count as empty.
`include "sorted_histogram_bucket_table_assert.svh"

module sorted_histogram_bucket_table #(
    parameter int CAPACITY = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_func,
    input  logic signed [7:0]    i_key_mantissa,
    input  logic signed [7:0]    i_key_exponent,
    input  logic [63:0]          i_amount,
    input  logic [15:0]          i_entry_index,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_status,
    output logic [63:0]          o_applied_count,
    output logic signed [7:0]    o_entry_mantissa,
    output logic signed [7:0]    o_entry_exponent,
    output logic [15:0]          o_entries_used
);
    import shbt_pkg::*;

    localparam int TOT_W  = $clog2(CAPACITY + 1);
    localparam int LEVELS = reduce_levels(CAPACITY);
    localparam int WAIT_W = $clog2(LEVELS + 1);

    t_state             r_state;
    t_state             n_state;
    t_req               r_req;
    logic [TOT_W-1:0]   r_total;
    logic [TOT_W-1:0]   n_total;
    logic [WAIT_W-1:0]  r_wait;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [63:0]        r_out_applied;
    logic [7:0]         r_out_mant;
    logic [7:0]         r_out_exp;
    logic [15:0]        r_out_used;

    t_status            n_status;
    logic [63:0]        n_applied;
    logic [7:0]         n_mant;
    logic [7:0]         n_exp;

    t_cmd               w_cmd;
    t_hit               w_sel;
    logic               w_in_beat;
    logic               w_commit;
    logic               w_amt_nz;
    logic               w_full;
    logic               w_found;

    t_link                     w_link [CAPACITY+1];
    logic [CAPACITY*HIT_W-1:0] w_hits;

    assign w_in_beat = i_valid && o_ready;
    assign w_amt_nz  = |r_req.amount;
    assign w_full    = r_total == TOT_W'(CAPACITY);
    assign w_found   = w_sel.hit;

    // ------------------------------------------------------------------------
    // Cell row and result reduction
    // ------------------------------------------------------------------------
    assign w_link[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_hit w_hit;

        shbt_cell #(
            .TOT_W (TOT_W),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_req   (r_req),
            .i_total (r_total),
            .i_cmd   (w_cmd),
            .i_prev  (w_link[g]),
            .o_next  (w_link[g+1]),
            .o_hit   (w_hit)
        );

        assign w_hits[g*HIT_W +: HIT_W] = w_hit;
    end

    shbt_or_tree #(
        .N (CAPACITY),
        .W (HIT_W)
    ) u_tree (
        .i_clk  (i_clk),
        .i_data (w_hits),
        .o_data (w_sel)
    );

    // ------------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_beat) begin
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (r_wait == WAIT_W'(LEVELS - 1)) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready  = 1'b0;
        w_commit = 1'b0;
        w_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
            end
            S_COMMIT: begin
                // Hold the commit while an earlier result is still unread.
                w_commit = !r_out_valid || i_ready;
                w_cmd.upd = w_commit && w_amt_nz && w_found
                            && (r_req.func == FUNC_INSERT || r_req.func == FUNC_REMOVE);
                w_cmd.ins = w_commit && w_amt_nz && !w_found && !w_full
                            && (r_req.func == FUNC_INSERT);
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_status  = STAT_OK;
        n_applied = '0;
        n_mant    = '0;
        n_exp     = '0;
        n_total   = r_total;
        case (r_req.func)
            FUNC_INSERT: begin
                if (w_amt_nz) begin
                    if (w_found) begin
                        n_applied = w_sel.value;
                    end else if (w_full) begin
                        n_status = STAT_FULL;
                    end else begin
                        n_applied = r_req.amount;
                        n_total   = r_total + TOT_W'(1);
                    end
                end
            end
            FUNC_REMOVE: begin
                if (w_amt_nz && w_found) begin
                    n_applied = w_sel.value;
                end
            end
            FUNC_READ: begin
                if (w_found) begin
                    n_applied = w_sel.value;
                    n_mant    = w_sel.key[15:8];
                    n_exp     = w_sel.key[7:0];
                end else begin
                    n_status = STAT_RANGE;
                end
            end
            FUNC_CLEAR: begin
                n_total = '0;
            end
            default: begin
                n_total = r_total;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_beat) begin
                r_wait <= '0;
            end else if (r_state == S_REDUCE) begin
                r_wait <= r_wait + WAIT_W'(1);
            end
            if (w_commit) begin
                r_total     <= n_total;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_req.func   <= t_func'(i_func);
            r_req.key    <= {i_key_mantissa, i_key_exponent};
            r_req.amount <= i_amount;
            r_req.index  <= i_entry_index;
        end
        if (w_commit) begin
            r_out_status  <= n_status;
            r_out_applied <= n_applied;
            r_out_mant    <= n_mant;
            r_out_exp     <= n_exp;
            r_out_used    <= 16'(n_total);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_applied_count  = r_out_applied;
    assign o_entry_mantissa = r_out_mant;
    assign o_entry_exponent = r_out_exp;
    assign o_entries_used   = r_out_used;

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
    `SHBT_ASSERT_SAME(a_total_bound, i_clk, i_rst_n, 1'b1, r_total <= TOT_W'(CAPACITY))
    `SHBT_ASSERT_SAME(a_used_tracks, i_clk, i_rst_n, r_out_valid, 16'(r_total) == r_out_used)
    `SHBT_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, w_cmd.ins, r_total == $past(r_total) + TOT_W'(1))
    `SHBT_ASSERT_SAME(a_error_zero, i_clk, i_rst_n, r_out_valid && r_out_status != STAT_OK, r_out_applied == 64'd0)

endmodule

// ===== rtl/core/shbt_cell.sv =====
// ----------------------------------------------------------------------------
// Bucket table cell
// Holds one table position; compares, updates and shifts from its neighbor.
// ----------------------------------------------------------------------------
module shbt_cell #(
    parameter int TOT_W = 9,
    parameter int IDX   = 0
) (
    input  logic                         i_clk,
    input  shbt_pkg::t_req               i_req,
    input  logic [TOT_W-1:0]             i_total,
    input  shbt_pkg::t_cmd               i_cmd,
    input  shbt_pkg::t_link              i_prev,
    output shbt_pkg::t_link              o_next,
    output shbt_pkg::t_hit               o_hit
);
    import shbt_pkg::*;

    logic [KEY_W-1:0]   r_key;
    logic [COUNT_W-1:0] r_count;

    logic               w_valid;
    logic               w_match;
    logic               w_gt;
    logic [COUNT_W:0]   w_sum;
    logic [COUNT_W-1:0] w_ins_new;
    logic [COUNT_W-1:0] w_ins_app;
    logic               w_under;
    logic [COUNT_W-1:0] w_rem_new;
    logic [COUNT_W-1:0] w_rem_app;

    assign w_valid = TOT_W'(IDX) < i_total;
    assign w_match = w_valid && (r_key == i_req.key);
    assign w_gt    = !w_valid || (key_rank(r_key) > key_rank(i_req.key));

    // Saturating add and floored subtract.
    assign w_sum     = {1'b0, r_count} + {1'b0, i_req.amount};
    assign w_ins_new = w_sum[COUNT_W] ? '1 : w_sum[COUNT_W-1:0];
    assign w_ins_app = w_sum[COUNT_W] ? ~r_count : i_req.amount;
    assign w_under   = i_req.amount >= r_count;
    assign w_rem_new = w_under ? '0 : r_count - i_req.amount;
    assign w_rem_app = w_under ? r_count : i_req.amount;

    assign o_next = '{gt: w_gt, key: r_key, count: r_count};

    always_comb begin
        o_hit = '0;
        case (i_req.func)
            FUNC_INSERT: begin
                if (w_match) begin
                    o_hit.hit   = 1'b1;
                    o_hit.value = w_ins_app;
                end
            end
            FUNC_REMOVE: begin
                if (w_match) begin
                    o_hit.hit   = 1'b1;
                    o_hit.value = w_rem_app;
                end
            end
            FUNC_READ: begin
                if (w_valid && i_req.index == IDX_W'(IDX)) begin
                    o_hit.hit   = 1'b1;
                    o_hit.value = r_count;
                    o_hit.key   = r_key;
                end
            end
            default: begin
                o_hit = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd && w_match) begin
            r_count <= (i_req.func == FUNC_INSERT) ? w_ins_new : w_rem_new;
        end else if (i_cmd.ins && w_gt) begin
            // First cell past the key takes the new bucket; later ones shift up.
            if (!i_prev.gt) begin
                r_key   <= i_req.key;
                r_count <= i_req.amount;
            end else begin
                r_key   <= i_prev.key;
                r_count <= i_prev.count;
            end
        end
    end

endmodule

// ===== rtl/core/shbt_or_tree.sv =====
// ----------------------------------------------------------------------------
// Bucket table reduction tree
// Registered OR reduction of the cell results, sixteen leaves per level.
// ----------------------------------------------------------------------------
module shbt_or_tree #(
    parameter int N = 256,
    parameter int W = 81
) (
    input  logic             i_clk,
    input  logic [N*W-1:0]   i_data,
    output logic [W-1:0]     o_data
);
    import shbt_pkg::*;

    localparam int NG = (N + OR_FANIN - 1) / OR_FANIN;

    if (NG == 1) begin : g_root
        logic [W-1:0] r_or;
        logic [W-1:0] n_or;

        always_comb begin
            n_or = '0;
            for (int k = 0; k < N; k++) begin
                n_or = n_or | i_data[k*W +: W];
            end
        end

        always_ff @(posedge i_clk) begin
            r_or <= n_or;
        end

        assign o_data = r_or;
    end else begin : g_level
        logic [NG*W-1:0] r_grp;

        for (genvar g = 0; g < NG; g++) begin : g_grp
            localparam int LO  = g * OR_FANIN;
            localparam int CNT = (N - LO < OR_FANIN) ? N - LO : OR_FANIN;
            logic [W-1:0] n_grp;

            always_comb begin
                n_grp = '0;
                for (int k = 0; k < CNT; k++) begin
                    n_grp = n_grp | i_data[(LO+k)*W +: W];
                end
            end

            always_ff @(posedge i_clk) begin
                r_grp[g*W +: W] <= n_grp;
            end
        end

        shbt_or_tree #(
            .N (NG),
            .W (W)
        ) u_next (
            .i_clk  (i_clk),
            .i_data (r_grp),
            .o_data (o_data)
        );
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bucket table testbench
// Sends insert, remove, read and clear beats to the sorted bucket table and
// checks every reply against a shadow copy of the table kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;

    import shbt_pkg::*;

    localparam int          CAPACITY     = 256;
    localparam int          POOL_SIZE    = 24;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          DRAIN_LIMIT  = 5000;
    localparam longint      TIMEOUT_NS   = 10_000_000;
    localparam logic [63:0] COUNT_MAX    = '1;

    typedef struct packed {
        t_status     status;
        logic [63:0] applied;
        logic [7:0]  mantissa;
        logic [7:0]  exponent;
        logic [15:0] used;
    } t_bucket_reply;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_func;
    logic signed [7:0]  i_key_mantissa;
    logic signed [7:0]  i_key_exponent;
    logic [63:0]        i_amount;
    logic [15:0]        i_entry_index;
    logic               o_valid;
    logic               i_ready;
    logic [1:0]         o_status;
    logic [63:0]        o_applied_count;
    logic signed [7:0]  o_entry_mantissa;
    logic signed [7:0]  o_entry_exponent;
    logic [15:0]        o_entries_used;

    // Shadow copy of the sorted table
    logic [15:0]   shadow_keys [CAPACITY];
    logic [63:0]   shadow_counts [CAPACITY];
    int            shadow_used;

    t_bucket_reply pending_replies [$];
    logic [15:0]   key_pool [POOL_SIZE];
    int            fail_count;
    int            send_idle_pct;
    int            stall_pct;

    sorted_histogram_bucket_table #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_func           (i_func),
        .i_key_mantissa   (i_key_mantissa),
        .i_key_exponent   (i_key_exponent),
        .i_amount         (i_amount),
        .i_entry_index    (i_entry_index),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_applied_count  (o_applied_count),
        .o_entry_mantissa (o_entry_mantissa),
        .o_entry_exponent (o_entry_exponent),
        .o_entries_used   (o_entries_used)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Sort position of a key: NaN group, negative, zero, positive mantissas
    function automatic logic [17:0] bucket_order(input logic [15:0] key);
        logic [7:0] mant;
        logic [7:0] exp_off;
        logic [7:0] mant_off;
        mant     = key[15:8];
        exp_off  = key[7:0] + 8'd128;
        mant_off = mant + 8'd128;
        if (mant == 8'hFF)
            return {2'd0, exp_off, 8'd0};
        else if (mant[7])
            return {2'd1, 8'd255 - exp_off, mant_off};
        else if (mant == 8'd0)
            return {2'd2, exp_off, 8'd0};
        else
            return {2'd3, exp_off, mant_off};
    endfunction

    // Position of key, or where it would go when absent
    function automatic int find_bucket(input logic [15:0] key, output bit hit);
        logic [17:0] want;
        int          pos;
        want = bucket_order(key);
        hit  = 1'b0;
        for (pos = 0; pos < shadow_used; pos++) begin
            if (bucket_order(shadow_keys[pos]) == want) begin
                hit = 1'b1;
                return pos;
            end
            if (bucket_order(shadow_keys[pos]) > want)
                return pos;
        end
        return pos;
    endfunction

    function automatic t_bucket_reply apply_op(input t_func func, input logic [15:0] key,
                                               input logic [63:0] amount,
                                               input logic [15:0] index);
        t_bucket_reply reply;
        bit            hit;
        int            pos;
        int            j;
        logic [64:0]   sum;
        reply        = '0;
        reply.status = STAT_OK;
        case (func)
            FUNC_INSERT: begin
                if (amount != 64'd0) begin
                    pos = find_bucket(key, hit);
                    if (hit) begin
                        sum = {1'b0, shadow_counts[pos]} + {1'b0, amount};
                        if (sum[64])
                            sum[63:0] = COUNT_MAX;
                        reply.applied      = sum[63:0] - shadow_counts[pos];
                        shadow_counts[pos] = sum[63:0];
                    end else if (shadow_used >= CAPACITY) begin
                        reply.status = STAT_FULL;
                    end else begin
                        for (j = shadow_used; j > pos; j--) begin
                            shadow_keys[j]   = shadow_keys[j-1];
                            shadow_counts[j] = shadow_counts[j-1];
                        end
                        shadow_keys[pos]   = key;
                        shadow_counts[pos] = amount;
                        shadow_used++;
                        reply.applied = amount;
                    end
                end
            end
            FUNC_REMOVE: begin
                if (amount != 64'd0) begin
                    pos = find_bucket(key, hit);
                    if (hit) begin
                        // floor at zero, the bucket itself stays
                        if (amount >= shadow_counts[pos]) begin
                            reply.applied      = shadow_counts[pos];
                            shadow_counts[pos] = 64'd0;
                        end else begin
                            reply.applied      = amount;
                            shadow_counts[pos] = shadow_counts[pos] - amount;
                        end
                    end
                end
            end
            FUNC_READ: begin
                if (index < shadow_used) begin
                    reply.applied  = shadow_counts[index];
                    reply.mantissa = shadow_keys[index][15:8];
                    reply.exponent = shadow_keys[index][7:0];
                end else begin
                    reply.status = STAT_RANGE;
                end
            end
            default: begin
                shadow_used = 0;
            end
        endcase
        reply.used = 16'(shadow_used);
        return reply;
    endfunction

    function automatic logic [15:0] mk_key(input int mant, input int expo);
        return {8'(mant), 8'(expo)};
    endfunction

    function automatic logic [15:0] random_key();
        logic [7:0] mant;
        case ($urandom_range(5))
            0:       mant = 8'hFF;
            1:       mant = 8'h00;
            2:       mant = 8'h80;
            3:       mant = 8'h7F;
            default: mant = 8'($urandom);
        endcase
        return {mant, 8'($urandom)};
    endfunction

    function automatic logic [63:0] random_amount();
        case ($urandom_range(9))
            0:       return 64'd0;
            1, 2:    return COUNT_MAX - 64'($urandom_range(3));
            3, 4, 5: return {$urandom, $urandom};
            default: return 64'($urandom_range(1, 1000));
        endcase
    endfunction

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
            flag_error($sformatf("%s: expected %0h, got %0h", name, want, got));
    endtask

    // Send one beat; the shadow table advances when the beat is taken
    task automatic send_op(input t_func func, input logic [15:0] key,
                           input logic [63:0] amount, input logic [15:0] index);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_func         <= func;
        i_key_mantissa <= key[15:8];
        i_key_exponent <= key[7:0];
        i_amount       <= amount;
        i_entry_index  <= index;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        pending_replies.push_back(apply_op(func, key, amount, index));
    endtask

    task automatic set_pressure(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    always @(posedge i_clk) begin
        t_bucket_reply want;
        i_ready <= ($urandom_range(99) >= stall_pct);
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_replies.size() == 0) begin
                flag_error("result beat with nothing expected");
            end else begin
                want = pending_replies.pop_front();
                check_field("status", 64'(want.status), 64'(o_status));
                check_field("applied_count", want.applied, o_applied_count);
                check_field("entry_mantissa", 64'(want.mantissa),
                            64'($unsigned(o_entry_mantissa)));
                check_field("entry_exponent", 64'(want.exponent),
                            64'($unsigned(o_entry_exponent)));
                check_field("entries_used", 64'(want.used), 64'(o_entries_used));
            end
        end
    end

    task automatic test_directed();
        int k;
        set_pressure(0, 0);
        send_op(FUNC_READ, 16'h0000, 64'd0, 16'd0);            // empty table
        send_op(FUNC_INSERT, mk_key(3, 3), 64'd0, 16'd0);      // zero amount
        send_op(FUNC_INSERT, mk_key(-1, 5), 64'd10, 16'd0);    // NaN bucket
        send_op(FUNC_INSERT, mk_key(-1, -128), 64'd1, 16'd0);  // NaN, other exponent
        send_op(FUNC_INSERT, mk_key(-128, 127), COUNT_MAX, 16'd0);
        send_op(FUNC_INSERT, mk_key(0, -3), 64'd7, 16'd0);
        send_op(FUNC_INSERT, mk_key(127, -128), 64'd3, 16'd0);
        send_op(FUNC_INSERT, mk_key(1, 127), 64'd2, 16'd0);
        send_op(FUNC_INSERT, mk_key(-128, 127), 64'd5, 16'd0); // already saturated
        send_op(FUNC_INSERT, mk_key(0, -3), COUNT_MAX, 16'd0); // saturate
        send_op(FUNC_REMOVE, mk_key(127, -128), 64'd100, 16'd0); // floor at zero
        send_op(FUNC_REMOVE, mk_key(5, 5), 64'd1, 16'd0);      // absent key
        send_op(FUNC_REMOVE, mk_key(1, 127), 64'd0, 16'd0);    // zero amount
        send_op(FUNC_REMOVE, mk_key(1, 127), 64'd1, 16'd0);
        for (k = 0; k < 6; k++)
            send_op(FUNC_READ, random_key(), {$urandom, $urandom}, 16'(k));
        send_op(FUNC_READ, 16'hFFFF, COUNT_MAX, 16'hFFFF);
        send_op(FUNC_READ, 16'h0000, 64'd0, 16'd6);            // index equal to count
        send_op(FUNC_CLEAR, 16'hFFFF, COUNT_MAX, 16'hFFFF);
        send_op(FUNC_READ, 16'h0000, 64'd0, 16'd0);
        send_op(FUNC_REMOVE, mk_key(-1, 5), 64'd1, 16'd0);     // gone after clear
    endtask

    task automatic test_random(input int count);
        int          n;
        int          roll;
        logic [15:0] key;
        logic [15:0] index;
        for (n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            key  = ($urandom_range(9) < 7) ? key_pool[$urandom_range(POOL_SIZE-1)]
                                           : random_key();
            if (roll < 45) begin
                send_op(FUNC_INSERT, key, random_amount(), 16'($urandom));
            end else if (roll < 65) begin
                send_op(FUNC_REMOVE, key, random_amount(), 16'($urandom));
            end else if (roll < 97) begin
                index = ($urandom_range(3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(shadow_used));
                send_op(FUNC_READ, key, {$urandom, $urandom}, index);
            end else begin
                send_op(FUNC_CLEAR, key, {$urandom, $urandom}, 16'($urandom));
            end
        end
    endtask

    task automatic test_full_table();
        int          k;
        bit          hit;
        logic [15:0] key;
        send_op(FUNC_CLEAR, random_key(), 64'd0, 16'd0);
        while (shadow_used < CAPACITY)
            send_op(FUNC_INSERT, random_key(), random_amount(), 16'($urandom));
        // a new key is dropped, an existing one still counts
        do begin
            key = random_key();
            void'(find_bucket(key, hit));
        end while (hit);
        send_op(FUNC_INSERT, key, 64'($urandom_range(1, 1000)), 16'd0);
        send_op(FUNC_INSERT, shadow_keys[$urandom_range(CAPACITY-1)], 64'd9, 16'd0);
        send_op(FUNC_REMOVE, key, 64'd1, 16'd0);
        for (k = 0; k < 4; k++)
            send_op(FUNC_READ, random_key(), 64'd0, 16'($urandom_range(CAPACITY-1)));
        send_op(FUNC_READ, random_key(), 64'd0, 16'(CAPACITY-1));
        send_op(FUNC_READ, random_key(), 64'd0, 16'(CAPACITY));   // one past the end
        send_op(FUNC_CLEAR, random_key(), 64'd0, 16'd0);
    endtask

    initial begin
        int k;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_ready        <= 1'b0;
        i_func         <= FUNC_INSERT;
        i_key_mantissa <= 8'sd0;
        i_key_exponent <= 8'sd0;
        i_amount       <= 64'd0;
        i_entry_index  <= 16'd0;
        fail_count    = 0;
        shadow_used   = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        for (k = 0; k < POOL_SIZE; k++)
            key_pool[k] = random_key();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        set_pressure(0, 0);
        test_random(30);
        set_pressure(55, 0);
        test_random(30);
        set_pressure(0, 55);
        test_random(30);
        set_pressure(10, 10);
        test_random(30);
        test_full_table();

        i_valid <= 1'b0;
        for (k = 0; k < DRAIN_LIMIT && pending_replies.size() != 0; k++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_replies.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/shbt_pkg.sv
rtl/core/shbt_cell.sv
rtl/core/shbt_or_tree.sv
rtl/core/sorted_histogram_bucket_table.sv
sim/tb_top.sv
